### design/tmac_pkg.sv
// Shared types and constants of the triangular matrix-vector accumulate core.
`timescale 1ns / 1ps

package tmac_pkg;

  // Widths of the beat fields.
  localparam int ROW_W    = 6;
  localparam int FUNC_W   = 2;
  localparam int FACTOR_W = 18;
  localparam int NOISE_W  = 16;
  localparam int BASE_W   = 32;
  localparam int VALUE_W  = 32;
  localparam int PROD_W   = FACTOR_W + NOISE_W;

  // Packed widths on the ports, padded to whole bytes.
  localparam int IN_DATA_W  = 80;
  localparam int OUT_DATA_W = 40;

  // Configuration port.
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 7;
  localparam logic [CFG_INDEX_W-1:0] REG_MODE    = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_NPOINTS = 2'd1;
  localparam logic [CFG_DATA_W-1:0]  NPOINTS_RESET = 7'd64;

  // Item kinds carried in tuser.
  localparam logic [FUNC_W-1:0] FUNC_FACTOR = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_VECTOR = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_RUN    = 2'd2;

  // Control that travels alongside the memory read data into the datapath.
  typedef struct packed {
    logic valid;  // a product term is on its way
    logic first;  // first term of a row: the accumulator starts from the base
  } mac_ctl_t;

endpackage

### design/tmac_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps

module tmac_ram #(
  parameter int WIDTH = 18,
  parameter int DEPTH = 64,
  localparam int AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AddrW-1:0] wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AddrW-1:0] rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

### design/tmac_mac.sv
// Multiply, shift and accumulate datapath with 32-bit saturation of the row sum.
`timescale 1ns / 1ps

module tmac_mac #(
  parameter int FRAC_BITS = 14
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  tmac_pkg::mac_ctl_t                   ctl,
  input  logic signed [tmac_pkg::FACTOR_W-1:0] factor,
  input  logic signed [tmac_pkg::NOISE_W-1:0]  noise,
  input  logic signed [tmac_pkg::BASE_W-1:0]   base,
  output logic                                 busy,
  output logic        [tmac_pkg::VALUE_W-1:0]  sum
);

  localparam int TermW = tmac_pkg::PROD_W - FRAC_BITS;
  localparam int WideW = (TermW + tmac_pkg::ROW_W > tmac_pkg::BASE_W)
                         ? TermW + tmac_pkg::ROW_W : tmac_pkg::BASE_W;
  localparam int AccW  = WideW + 1;

  tmac_pkg::mac_ctl_t                   ctl2_r;
  logic signed [tmac_pkg::PROD_W-1:0]   prod_r;
  logic signed [AccW-1:0]               acc_r;
  logic signed [AccW-1:0]               acc_nxt;
  logic signed [tmac_pkg::PROD_W-1:0]   shifted;
  logic [AccW-1:tmac_pkg::VALUE_W-1]    top_bits;

  // The arithmetic shift floors, as the fixed-point format requires.
  assign shifted = prod_r >>> FRAC_BITS;

  always_comb begin
    acc_nxt = acc_r;
    if (ctl2_r.valid) begin
      acc_nxt = (ctl2_r.first ? AccW'(base) : acc_r) + AccW'(shifted);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl2_r <= '0;
    end else begin
      ctl2_r <= ctl;
    end
    prod_r <= tmac_pkg::PROD_W'(factor) * tmac_pkg::PROD_W'(noise);
    acc_r  <= acc_nxt;
  end

  // The sum fits in 32 bits when all bits from bit 31 upward agree.
  assign top_bits = acc_r[AccW-1:tmac_pkg::VALUE_W-1];

  always_comb begin
    if ((&top_bits) || !(|top_bits)) begin
      sum = acc_r[tmac_pkg::VALUE_W-1:0];
    end else if (acc_r[AccW-1]) begin
      sum = {1'b1, {(tmac_pkg::VALUE_W-1){1'b0}}};
    end else begin
      sum = {1'b0, {(tmac_pkg::VALUE_W-1){1'b1}}};
    end
  end

  assign busy = ctl2_r.valid;

endmodule

### design/triangular_matvec_accumulate_core.sv
// Top level of the triangular matrix-vector accumulate core.
`timescale 1ns / 1ps

// Colors a stored noise vector by a stored square-root factor and adds each row
// sum to a stored base value. Load beats (factor entry, or noise and base pair)
// are written straight into the factor memory (MAX_POINTS squared entries) and
// the two vector memories. A run beat walks the terms row by row through one
// multiplier fed by one read port of the factor memory, one term per cycle,
// n*(n+1)/2 terms in triangular mode and n*n terms in full mode for n points in
// use; after each row it waits for the read and multiply stages to flush and for
// the output register to be free before the row's result beat is written. The
// input is not ready during a run; the final result of a run may still wait in
// the output register while the next beat is taken.
// Memory contents are undefined after reset and must be loaded before a run.
module triangular_matvec_accumulate_core #(
  parameter int MAX_POINTS       = 64,
  parameter int FACTOR_FRAC_BITS = 14
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // tdata fields from bit 0: row, col, factor_value, noise, base, zero pad
  input  logic [tmac_pkg::IN_DATA_W-1:0]       in_tdata,
  // tuser fields from bit 0: func
  input  logic [tmac_pkg::FUNC_W-1:0]          in_tuser,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  // tdata fields from bit 0: index, value, zero pad
  output logic [tmac_pkg::OUT_DATA_W-1:0]      out_tdata,
  output logic                                 out_tlast,
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [tmac_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [tmac_pkg::CFG_DATA_W-1:0]      cfg_data
);

  localparam int PtrW   = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int FDepth = MAX_POINTS * MAX_POINTS;
  localparam int FAddrW = (FDepth > 1) ? $clog2(FDepth) : 1;
  localparam int ChkW   = tmac_pkg::ROW_W + 1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_ISSUE,
    S_DRAIN
  } state_t;

  // Input beat fields.
  logic [tmac_pkg::ROW_W-1:0]           in_row;
  logic [tmac_pkg::ROW_W-1:0]           in_col;
  logic [tmac_pkg::FACTOR_W-1:0]        in_factor_value;
  logic [tmac_pkg::NOISE_W-1:0]         in_noise;
  logic [tmac_pkg::BASE_W-1:0]          in_base;

  state_t                               state_r, state_nxt;
  logic                                 mode_r;
  logic [tmac_pkg::CFG_DATA_W-1:0]      npoints_r;
  logic                                 run_mode_r, run_mode_nxt;
  logic [PtrW-1:0]                      last_idx_r, last_idx_nxt;
  logic [PtrW-1:0]                      row_r, row_nxt;
  logic [PtrW-1:0]                      col_r, col_nxt;
  tmac_pkg::mac_ctl_t                   ctl_r, ctl_nxt;
  logic                                 out_valid_r, out_valid_nxt;
  logic [tmac_pkg::ROW_W-1:0]           out_index_r, out_index_nxt;
  logic [tmac_pkg::VALUE_W-1:0]         out_value_r, out_value_nxt;
  logic                                 out_last_r, out_last_nxt;

  logic                                 in_accept;
  logic                                 row_ok;
  logic                                 col_ok;
  logic [tmac_pkg::CFG_DATA_W-1:0]      npts_use;
  logic                                 col_last;
  logic                                 row_last;
  logic                                 slot_free;

  logic                                 f_wr_en;
  logic [FAddrW-1:0]                    f_wr_addr;
  logic [FAddrW-1:0]                    f_rd_addr;
  logic [tmac_pkg::FACTOR_W-1:0]        f_rd_data;
  logic                                 v_wr_en;
  logic [tmac_pkg::NOISE_W-1:0]         n_rd_data;
  logic [tmac_pkg::BASE_W-1:0]          b_rd_data;
  logic                                 mac_busy;
  logic [tmac_pkg::VALUE_W-1:0]         mac_sum;

  assign in_row          = in_tdata[5:0];
  assign in_col          = in_tdata[11:6];
  assign in_factor_value = in_tdata[29:12];
  assign in_noise        = in_tdata[45:30];
  assign in_base         = in_tdata[77:46];

  assign in_tready = (state_r == S_IDLE);
  assign in_accept = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  assign row_ok = {1'b0, in_row} < ChkW'(MAX_POINTS);
  assign col_ok = {1'b0, in_col} < ChkW'(MAX_POINTS);

  // Load beats go straight to the memories.
  always_comb begin
    f_wr_en = 1'b0;
    v_wr_en = 1'b0;
    case (in_tuser)
      tmac_pkg::FUNC_FACTOR: f_wr_en = in_accept && row_ok && col_ok;
      tmac_pkg::FUNC_VECTOR: v_wr_en = in_accept && row_ok;
      default: ;
    endcase
  end

  assign f_wr_addr = FAddrW'(PtrW'(in_row)) * FAddrW'(MAX_POINTS) + FAddrW'(PtrW'(in_col));

  // Full mode walks factor[i][j]; triangular mode walks the transposed factor[j][i].
  assign f_rd_addr = run_mode_r
                     ? FAddrW'(row_r) * FAddrW'(MAX_POINTS) + FAddrW'(col_r)
                     : FAddrW'(col_r) * FAddrW'(MAX_POINTS) + FAddrW'(row_r);

  always_comb begin
    if (npoints_r == '0) begin
      npts_use = tmac_pkg::CFG_DATA_W'(1);
    end else if (npoints_r > tmac_pkg::CFG_DATA_W'(MAX_POINTS)) begin
      npts_use = tmac_pkg::CFG_DATA_W'(MAX_POINTS);
    end else begin
      npts_use = npoints_r;
    end
  end

  assign col_last  = run_mode_r ? (col_r == last_idx_r) : (col_r == row_r);
  assign row_last  = (row_r == last_idx_r);
  assign slot_free = !out_valid_r || out_tready;

  always_comb begin
    state_nxt     = state_r;
    run_mode_nxt  = run_mode_r;
    last_idx_nxt  = last_idx_r;
    row_nxt       = row_r;
    col_nxt       = col_r;
    ctl_nxt       = '0;
    out_valid_nxt = out_valid_r && !out_tready;
    out_index_nxt = out_index_r;
    out_value_nxt = out_value_r;
    out_last_nxt  = out_last_r;
    case (state_r)
      S_IDLE: begin
        if (in_accept && in_tuser == tmac_pkg::FUNC_RUN) begin
          run_mode_nxt = mode_r;
          last_idx_nxt = PtrW'(npts_use - tmac_pkg::CFG_DATA_W'(1));
          row_nxt      = '0;
          col_nxt      = '0;
          state_nxt    = S_ISSUE;
        end
      end
      S_ISSUE: begin
        ctl_nxt.valid = 1'b1;
        ctl_nxt.first = (col_r == '0);
        col_nxt       = col_r + PtrW'(1);
        if (col_last) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        // The row sum is complete once both datapath stages are empty.
        if (!ctl_r.valid && !mac_busy && slot_free) begin
          out_valid_nxt = 1'b1;
          out_index_nxt = tmac_pkg::ROW_W'(row_r);
          out_value_nxt = mac_sum;
          out_last_nxt  = row_last;
          col_nxt       = '0;
          row_nxt       = row_r + PtrW'(1);
          state_nxt     = row_last ? S_IDLE : S_ISSUE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      mode_r      <= 1'b0;
      npoints_r   <= tmac_pkg::NPOINTS_RESET;
      ctl_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ctl_r       <= ctl_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          tmac_pkg::REG_MODE:    mode_r    <= cfg_data[0];
          tmac_pkg::REG_NPOINTS: npoints_r <= cfg_data;
          default: ;
        endcase
      end
    end
    run_mode_r  <= run_mode_nxt;
    last_idx_r  <= last_idx_nxt;
    row_r       <= row_nxt;
    col_r       <= col_nxt;
    out_index_r <= out_index_nxt;
    out_value_r <= out_value_nxt;
    out_last_r  <= out_last_nxt;
  end

  tmac_ram #(
    .WIDTH (tmac_pkg::FACTOR_W),
    .DEPTH (FDepth)
  ) u_factor_ram (
    .clk     (clk),
    .wr_en   (f_wr_en),
    .wr_addr (f_wr_addr),
    .wr_data (in_factor_value),
    .rd_addr (f_rd_addr),
    .rd_data (f_rd_data)
  );

  tmac_ram #(
    .WIDTH (tmac_pkg::NOISE_W),
    .DEPTH (MAX_POINTS)
  ) u_noise_ram (
    .clk     (clk),
    .wr_en   (v_wr_en),
    .wr_addr (PtrW'(in_row)),
    .wr_data (in_noise),
    .rd_addr (col_r),
    .rd_data (n_rd_data)
  );

  tmac_ram #(
    .WIDTH (tmac_pkg::BASE_W),
    .DEPTH (MAX_POINTS)
  ) u_base_ram (
    .clk     (clk),
    .wr_en   (v_wr_en),
    .wr_addr (PtrW'(in_row)),
    .wr_data (in_base),
    .rd_addr (row_r),
    .rd_data (b_rd_data)
  );

  tmac_mac #(
    .FRAC_BITS (FACTOR_FRAC_BITS)
  ) u_mac (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (ctl_r),
    .factor (f_rd_data),
    .noise  (n_rd_data),
    .base   (b_rd_data),
    .busy   (mac_busy),
    .sum    (mac_sum)
  );

  assign out_tvalid = out_valid_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {2'b00, out_value_r, out_index_r};

endmodule

### tb/tmac_checker.sv
// Checker for the triangular matrix-vector accumulate core: predicts and compares results.
`timescale 1ns / 1ps

module tmac_checker (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // tdata fields from bit 0: row, col, factor_value, noise, base, zero pad
  input  logic [tmac_pkg::IN_DATA_W-1:0]       in_tdata,
  // tuser fields from bit 0: func
  input  logic [tmac_pkg::FUNC_W-1:0]          in_tuser,
  input  logic                                 in_tvalid,
  input  logic                                 in_tready,
  // tdata fields from bit 0: index, value, zero pad
  input  logic [tmac_pkg::OUT_DATA_W-1:0]      out_tdata,
  input  logic                                 out_tlast,
  input  logic                                 out_tvalid,
  input  logic                                 out_tready,
  input  logic                                 cfg_valid,
  input  logic                                 cfg_ready,
  input  logic [tmac_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [tmac_pkg::CFG_DATA_W-1:0]      cfg_data,
  output int                                   mismatches,
  output int                                   pending,
  output int                                   checked
);
  import tmac_pkg::*;

  localparam int POINTS    = 64;
  localparam int FRAC_BITS = 14;

  typedef struct packed {
    logic [ROW_W-1:0]   index;
    logic [VALUE_W-1:0] value;
    logic               last;
  } point_result_t;

  point_result_t              expected_points[$];
  point_result_t              seen;
  point_result_t              wanted;
  logic signed [FACTOR_W-1:0] factor_mem [0:POINTS*POINTS-1];
  logic signed [NOISE_W-1:0]  noise_mem [0:POINTS-1];
  logic signed [BASE_W-1:0]   base_mem [0:POINTS-1];
  logic                       mode_q;
  logic [CFG_DATA_W-1:0]      npoints_q;
  logic [ROW_W-1:0]           beat_row;
  logic [ROW_W-1:0]           beat_col;

  initial begin
    mismatches = 0;
    pending    = 0;
    checked    = 0;
  end

  // Colors the stored noise and queues one expected point per row in use.
  task automatic predict_colored_points();
    int                        n;
    int                        i;
    int                        j;
    int                        terms;
    longint                    acc;
    logic signed [PROD_W-1:0]  prod;
    logic signed [PROD_W-1:0]  scaled;
    point_result_t             pt;
    n = (npoints_q == '0) ? 1 : (int'(npoints_q) > POINTS) ? POINTS : int'(npoints_q);
    for (i = 0; i < n; i++) begin
      acc   = longint'(base_mem[i]);
      terms = mode_q ? n : i + 1;
      for (j = 0; j < terms; j++) begin
        if (mode_q)
          prod = PROD_W'(factor_mem[i*POINTS + j]) * PROD_W'(noise_mem[j]);
        else
          prod = PROD_W'(factor_mem[j*POINTS + i]) * PROD_W'(noise_mem[j]);
        // The arithmetic shift floors, matching the truncating datapath.
        scaled = prod >>> FRAC_BITS;
        acc    = acc + longint'(scaled);
      end
      if (acc > 64'sd2147483647)
        acc = 64'sd2147483647;
      else if (acc < -64'sd2147483648)
        acc = -64'sd2147483648;
      pt.index = i[ROW_W-1:0];
      pt.value = acc[VALUE_W-1:0];
      pt.last  = (i == n - 1);
      expected_points.push_back(pt);
      pending++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      mode_q    = 1'b0;
      npoints_q = NPOINTS_RESET;
    end else begin
      // A result beat at this edge always belongs to a run taken earlier.
      if (out_tvalid && out_tready) begin
        seen.index = out_tdata[ROW_W-1:0];
        seen.value = out_tdata[ROW_W +: VALUE_W];
        seen.last  = out_tlast;
        if (expected_points.size() == 0) begin
          if (mismatches < 10)
            $display("%0t: unexpected result index %0d value %0d last %0d", $time,
                     seen.index, $signed(seen.value), seen.last);
          mismatches++;
        end else begin
          wanted = expected_points.pop_front();
          pending--;
          checked++;
          if (seen != wanted) begin
            if (mismatches < 10)
              $display("%0t: got index %0d value %0d last %0d, %s %0d value %0d last %0d",
                       $time, seen.index, $signed(seen.value), seen.last,
                       "expected index", wanted.index, $signed(wanted.value), wanted.last);
            mismatches++;
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_MODE:    mode_q = cfg_data[0];
          REG_NPOINTS: npoints_q = cfg_data;
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) begin
        beat_row = in_tdata[0 +: ROW_W];
        beat_col = in_tdata[ROW_W +: ROW_W];
        case (in_tuser)
          FUNC_FACTOR: factor_mem[beat_row*POINTS + beat_col] = in_tdata[2*ROW_W +: FACTOR_W];
          FUNC_VECTOR: begin
            noise_mem[beat_row] = in_tdata[2*ROW_W + FACTOR_W +: NOISE_W];
            base_mem[beat_row]  = in_tdata[2*ROW_W + FACTOR_W + NOISE_W +: BASE_W];
          end
          FUNC_RUN: predict_colored_points();
          default: ;
        endcase
      end
    end
  end

endmodule

### tb/tb_triangular_matvec_accumulate_core.sv
// Testbench top of the triangular matrix-vector accumulate core: stimulus and verdict.
`timescale 1ns / 1ps

module tb_triangular_matvec_accumulate_core;
  import tmac_pkg::*;

  localparam int POINTS        = 64;
  localparam int CYCLE_LIMIT   = 1000000;
  localparam int HOLD_CYCLES   = 600;
  localparam int RANDOM_BEATS  = 250;
  localparam logic [FUNC_W-1:0]      FUNC_UNUSED    = 2'd3;
  localparam logic [CFG_INDEX_W-1:0] CFG_UNUSED_REG = 2'd3;

  logic                   clk;
  logic                   rst_n       = 1'b0;
  logic [IN_DATA_W-1:0]   in_tdata    = '0;
  logic [FUNC_W-1:0]      in_tuser    = '0;
  logic                   in_tvalid   = 1'b0;
  logic                   in_tready;
  logic [OUT_DATA_W-1:0]  out_tdata;
  logic                   out_tlast;
  logic                   out_tvalid;
  logic                   out_tready  = 1'b0;
  logic                   cfg_valid   = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index   = '0;
  logic [CFG_DATA_W-1:0]  cfg_data    = '0;

  int mismatches;
  int pending;
  int checked;
  int send_idle     = 32;
  int recv_idle     = 52;
  int cycle_count   = 0;
  int stall_left    = 0;
  int beats_sent    = 0;
  int runs_sent     = 0;
  int random_beats  = 0;
  bit count_random  = 1'b0;
  bit stall_request = 1'b0;
  bit factor_done [0:POINTS*POINTS-1];
  bit vector_done [0:POINTS-1];

  triangular_matvec_accumulate_core u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  tmac_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .mismatches (mismatches),
    .pending    (pending),
    .checked    (checked)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Sink side: random backpressure, or a long hold when one is requested.
  always @(posedge clk) begin
    if (stall_request) begin
      stall_left    = HOLD_CYCLES;
      stall_request = 1'b0;
    end
    if (stall_left > 0) begin
      stall_left--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_idle);
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results outstanding", cycle_count, pending);
      $display("Test completed with failures");
      $finish;
    end
  end

  // Random word of the given width, biased toward its signed extremes.
  function automatic logic [31:0] pick_word(input int unsigned width);
    logic [31:0] v;
    int unsigned r;
    r = $urandom_range(99);
    v = $urandom();
    if (r < 6)
      v = (32'h1 << (width - 1)) - 32'h1;
    else if (r < 12)
      v = 32'h1 << (width - 1);
    return v;
  endfunction

  // Valid stays high after a beat; the next call either idles or offers the next beat.
  task automatic send_beat(input logic [FUNC_W-1:0] func, input logic [ROW_W-1:0] row,
                           input logic [ROW_W-1:0] col, input logic [FACTOR_W-1:0] fac,
                           input logic [NOISE_W-1:0] nz, input logic [BASE_W-1:0] bs);
    while ($urandom_range(99) < send_idle) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tuser  <= func;
    in_tdata  <= {2'b00, bs, nz, fac, col, row};
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    beats_sent++;
    if (count_random && func != FUNC_UNUSED)
      random_beats++;
  endtask

  task automatic put_factor(input int unsigned r, input int unsigned c,
                            input logic [FACTOR_W-1:0] f);
    send_beat(FUNC_FACTOR, r[ROW_W-1:0], c[ROW_W-1:0], f, NOISE_W'($urandom()), $urandom());
    factor_done[r*POINTS + c] = 1'b1;
  endtask

  task automatic put_vector(input int unsigned idx, input logic [NOISE_W-1:0] nz,
                            input logic [BASE_W-1:0] bs);
    send_beat(FUNC_VECTOR, idx[ROW_W-1:0], ROW_W'($urandom()), FACTOR_W'($urandom()), nz, bs);
    vector_done[idx] = 1'b1;
  endtask

  task automatic run_beat();
    send_beat(FUNC_RUN, ROW_W'($urandom()), ROW_W'($urandom()), FACTOR_W'($urandom()),
              NOISE_W'($urandom()), $urandom());
    runs_sent++;
  endtask

  // Occasional stray beat: unused code or a write anywhere in the stores.
  task automatic maybe_stray();
    if ($urandom_range(99) < 6) begin
      case ($urandom_range(2))
        0: send_beat(FUNC_UNUSED, ROW_W'($urandom()), ROW_W'($urandom()),
                     FACTOR_W'($urandom()), NOISE_W'($urandom()), $urandom());
        1: put_factor($urandom_range(POINTS - 1), $urandom_range(POINTS - 1),
                      FACTOR_W'(pick_word(18)));
        default: put_vector($urandom_range(POINTS - 1), NOISE_W'(pick_word(16)),
                            pick_word(32));
      endcase
    end
  endtask

  // Lowers valid and waits until every expected result is back and the core is quiet.
  task automatic drain_results();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (8) @(posedge clk);
  endtask

  task automatic configure(input logic m, input logic [CFG_DATA_W-1:0] np);
    cfg_index <= REG_MODE;
    cfg_data  <= {{(CFG_DATA_W-1){1'b0}}, m};
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_index <= REG_NPOINTS;
    cfg_data  <= np;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // Loads every entry the run will read that is still unwritten, rewrites some at
  // random, then issues the run.
  task automatic load_and_run(input logic m, input int unsigned n,
                              input int unsigned rewrite_pct, input bit hold);
    int unsigned r;
    int unsigned c;
    for (r = 0; r < n; r++) begin
      if (!vector_done[r] || $urandom_range(99) < rewrite_pct)
        put_vector(r, NOISE_W'(pick_word(16)), pick_word(32));
      maybe_stray();
    end
    for (r = 0; r < n; r++) begin
      for (c = m ? 0 : r; c < n; c++) begin
        if (!factor_done[r*POINTS + c] || $urandom_range(99) < rewrite_pct)
          put_factor(r, c, FACTOR_W'(pick_word(18)));
        maybe_stray();
      end
    end
    if (hold)
      stall_request = 1'b1;
    run_beat();
  endtask

  initial begin
    logic                  m;
    logic [CFG_DATA_W-1:0] np;
    int unsigned           n;
    int unsigned           r;

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: a write to an unused register, then one point with a zero count.
    cfg_index <= CFG_UNUSED_REG;
    cfg_data  <= '1;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    configure(1'b0, 7'd0);
    put_factor(0, 0, 18'sh1FFFF);
    put_vector(0, 16'sh7FFF, 32'sh7FFFFFFF);
    run_beat();                                     // saturates high
    put_vector(0, 16'sh8000, 32'sh80000000);
    run_beat();                                     // saturates low
    put_factor(0, 0, 18'sh20000);
    put_vector(0, 16'sh8000, 32'sh7FFFFC00);
    run_beat();                                     // most negative operands
    send_beat(FUNC_UNUSED, '1, '1, '1, '1, '1);
    drain_results();

    // Two points in both modes; a tiny negative product must floor to minus one.
    configure(1'b1, 7'd2);
    put_factor(0, 0, -18'sd1);
    put_factor(0, 1, 18'sd1);
    put_factor(1, 0, 18'sh1FFFF);
    put_factor(1, 1, 18'sh20000);
    put_vector(0, 16'sd1, 32'sd0);
    put_vector(1, 16'sd3, -32'sd5);
    run_beat();
    drain_results();
    configure(1'b0, 7'd2);
    run_beat();
    put_factor(POINTS - 1, POINTS - 1, 18'sh15555);
    put_vector(POINTS - 1, 16'shAAAA, 32'h55555555);
    drain_results();

    // Eight points in full mode: the sink holds off during the run while vector
    // writes keep waiting at the input.
    configure(1'b1, 7'd8);
    load_and_run(1'b1, 8, 0, 1'b1);
    repeat (8) put_vector($urandom_range(POINTS - 1), NOISE_W'(pick_word(16)), pick_word(32));
    drain_results();
    configure(1'b0, 7'd8);
    load_and_run(1'b0, 8, 2, 1'b0);

    // Random phases with changing settings and idle patterns.
    count_random = 1'b1;
    while (random_beats < RANDOM_BEATS) begin
      if (random_beats < RANDOM_BEATS / 3) begin
        send_idle = 32;
        recv_idle = 52;
      end else if (random_beats < 2 * RANDOM_BEATS / 3) begin
        send_idle = 52;
        recv_idle = 32;
      end else begin
        send_idle = 0;
        recv_idle = 0;
      end
      drain_results();
      m = 1'($urandom_range(1));
      r = $urandom_range(99);
      if (r < 6)
        np = 7'd0;
      else if (r < 12)
        np = 7'd1;
      else
        np = m ? 7'($urandom_range(2, 8)) : 7'($urandom_range(2, 10));
      n = (np == '0) ? 1 : int'(np);
      configure(m, np);
      repeat ($urandom_range(1, 3)) load_and_run(m, n, 30, 1'b0);
    end

    drain_results();
    repeat (20) @(posedge clk);
    $display("Drove %0d beats with %0d runs in both modes, 1 to 10 points, under three idle mixes",
             beats_sent, runs_sent);
    $display("Compared %0d results, including saturation and a long sink hold", checked);
    if (mismatches == 0 && pending == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

### files.f
design/tmac_pkg.sv
design/tmac_ram.sv
design/tmac_mac.sv
design/triangular_matvec_accumulate_core.sv
tb/tmac_checker.sv
tb/tb_triangular_matvec_accumulate_core.sv
